// ===== rtl/core/psg_pkg.sv =====
// Shared constants and arithmetic helpers for the particle surface growth step.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none
package psg_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE          = 3'd0;
    localparam logic [2:0] REG_REF_INCREMENT = 3'd1;
    localparam logic [2:0] REG_REF_SIZE      = 3'd2;
    localparam logic [2:0] REG_MAX_SIZE      = 3'd3;
    localparam logic [2:0] REG_BIN_WIDTH     = 3'd4;
    localparam logic [2:0] REG_AGE_FACTOR    = 3'd5;

    // Operating modes.
    localparam logic [1:0] MODE_GROWTH = 2'd0;
    localparam logic [1:0] MODE_OXID   = 2'd1;
    localparam logic [1:0] MODE_AGING  = 2'd2;

    // Exponent 0.6666 and the exp2 polynomial coefficients, all Q16.
    localparam logic [15:0] EXP_Q16 = 16'd43686;
    localparam logic [15:0] EXP2_A  = 16'd43025;
    localparam logic [15:0] EXP2_B  = 16'd22511;

    // Widths of intermediate values.
    localparam int LOG_W = 21;  // 5 integer bits, 16 fraction bits
    localparam int INC_W = 35;  // signed increment clamped to +-2^33
    localparam int Q_W   = 30;  // aging quotient, capped at 2^29

    localparam logic [Q_W-1:0] AGE_Q_CAP = 30'h2000_0000;

    typedef logic signed [INC_W-1:0] inc_t;
    typedef logic signed [65:0]      wide_t;

    // Signed division by 65536 with truncation toward zero.
    function automatic wide_t div_q16(input wide_t v);
        wide_t a;
        begin
            a = v[65] ? (v + 66'sd65535) : v;
            return a >>> 16;
        end
    endfunction

    // Clamp to +-2^33.
    function automatic inc_t clamp_inc(input wide_t v);
        wide_t lim;
        begin
            lim = 66'sd8589934592;
            if (v > lim) begin
                return inc_t'(lim);
            end else if (v < -lim) begin
                return inc_t'(-lim);
            end
            return inc_t'(v);
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/psg_log2.sv =====
// Pipelined Q16 log2 of a 32-bit raw value: normalize, then sixteen squaring stages.
// Depends on psg_pkg.
`default_nettype none
module psg_log2 (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic [31:0]                x,
    output logic      [psg_pkg::LOG_W-1:0]  r
);
    import psg_pkg::*;

    localparam int STEPS = 16;

    logic [4:0]  k_reg  [0:STEPS];
    logic [31:0] m_reg  [0:STEPS];
    logic [15:0] fr_reg [0:STEPS];

    logic [4:0]  k_in;
    logic [31:0] m_in;

    // Index of the leading one; a zero input gives index zero.
    always_comb begin
        k_in = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                k_in = 5'(i);
            end
        end
        m_in = x << (5'd31 - k_in);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_reg[0]  <= k_in;
            m_reg[0]  <= m_in;
            fr_reg[0] <= 16'd0;
        end
    end

    for (genvar j = 1; j <= STEPS; j++) begin : g_sq
        logic [63:0] sq;
        logic [32:0] t;
        logic [31:0] m_next;
        logic [15:0] fr_next;

        always_comb begin
            sq      = m_reg[j-1] * m_reg[j-1];
            t       = sq[63:31];
            m_next  = t[32] ? t[32:1] : t[31:0];
            fr_next = fr_reg[j-1];
            fr_next[STEPS-j] = t[32];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                k_reg[j]  <= k_reg[j-1];
                m_reg[j]  <= m_next;
                fr_reg[j] <= fr_next;
            end
        end
    end

    assign r = {k_reg[STEPS], fr_reg[STEPS]};

endmodule
`default_nettype wire

// ===== rtl/core/psg_agediv.sv =====
// Pipelined aging quotient 4*age_factor*size/max_size, one quotient bit per stage.
// Depends on psg_pkg.
`default_nettype none
module psg_agediv (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic [15:0]              age,
    input  wire logic [31:0]              size,
    input  wire logic [31:0]              divisor,
    output logic      [psg_pkg::Q_W-1:0]  q
);
    import psg_pkg::*;

    localparam int QB = 31;

    logic [49:0] numer_reg;
    logic [31:0] dv0_reg;
    logic [49:0] rem_reg  [0:QB];
    logic [30:0] quot_reg [0:QB];
    logic [31:0] dv_reg   [0:QB];
    logic        ovf_reg  [0:QB];
    logic [Q_W-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            numer_reg <= {age, 2'b00} * size;
            dv0_reg   <= divisor;
            rem_reg[0]  <= numer_reg;
            quot_reg[0] <= 31'd0;
            dv_reg[0]   <= dv0_reg;
            ovf_reg[0]  <= {13'd0, numer_reg} >= {dv0_reg, 31'd0};
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_div
        logic [62:0] cand;
        logic        take;
        logic [49:0] rem_next;
        logic [30:0] quot_next;

        always_comb begin
            cand      = {31'd0, dv_reg[j-1]} << (QB - j);
            take      = {13'd0, rem_reg[j-1]} >= cand;
            rem_next  = take ? 50'(rem_reg[j-1] - cand[49:0]) : rem_reg[j-1];
            quot_next = quot_reg[j-1];
            quot_next[QB-j] = take;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                quot_reg[j] <= quot_next;
                dv_reg[j]   <= dv_reg[j-1];
                ovf_reg[j]  <= ovf_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (ovf_reg[QB] || quot_reg[QB] > {1'b0, AGE_Q_CAP}) begin
                q_reg <= AGE_Q_CAP;
            end else begin
                q_reg <= quot_reg[QB][Q_W-1:0];
            end
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// ===== rtl/core/psg_incr.sv =====
// Pipelined size scaling: (size/ref)^0.6666 through exp2 of the log difference,
// then the product with the reference increment. Depends on psg_pkg.
`default_nettype none
module psg_incr (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic [psg_pkg::LOG_W-1:0]  log_s,
    input  wire logic [psg_pkg::LOG_W-1:0]  log_r,
    input  wire logic                       zero,
    input  wire logic [31:0]                ref_inc,
    output psg_pkg::inc_t                   inc
);
    import psg_pkg::*;

    // Stage 1: absolute log difference.
    logic [LOG_W-1:0] s1_ad_reg;
    logic             s1_neg_reg, s1_zero_reg;
    // Stage 2: scaled exponent magnitude.
    logic [LOG_W-1:0] s2_em_reg;
    logic             s2_neg_reg, s2_zero_reg;
    // Stage 3: integer and fraction of the exponent.
    logic [15:0]       s3_f_reg;
    logic [15:0]       s3_t_reg;
    logic signed [7:0] s3_n_reg;
    logic              s3_zero_reg;
    // Stage 4: 2^f.
    logic [16:0]       s4_p_reg;
    logic signed [7:0] s4_n_reg;
    logic              s4_zero_reg;
    // Stages 5 to 7.
    logic [31:0]        s5_scale_reg;
    logic signed [64:0] s6_prod_reg;
    inc_t               s7_inc_reg;

    // The reference increment must stay static while items flow; this module does not enforce it.
    logic signed [31:0] ri;
    assign ri = $signed(ref_inc);

    logic signed [LOG_W:0] d;
    logic [36:0]           em_prod;
    logic signed [LOG_W:0] e;
    logic [22:0]           eu;
    logic [31:0]           t_prod;
    logic [31:0]           p_prod;
    logic [37:0]           sh_up;
    logic [7:0]            n_neg;
    logic [31:0]           scale;

    always_comb begin
        d       = $signed({1'b0, log_s}) - $signed({1'b0, log_r});
        em_prod = s1_ad_reg * EXP_Q16 + 37'd32768;
        e       = s2_neg_reg ? -$signed({1'b0, s2_em_reg}) : $signed({1'b0, s2_em_reg});
        eu      = 23'({e[LOG_W], e}) + 23'd4194304;
        t_prod  = EXP2_B * eu[15:0];
        p_prod  = s3_f_reg * (EXP2_A + s3_t_reg);
        sh_up   = {21'd0, s4_p_reg} << s4_n_reg[4:0];
        n_neg   = 8'(-s4_n_reg);
        if (s4_zero_reg) begin
            scale = 32'd0;
        end else if (!s4_n_reg[7]) begin
            scale = (sh_up[37:32] != 6'd0) ? 32'hFFFF_FFFF : sh_up[31:0];
        end else begin
            scale = {15'd0, s4_p_reg >> n_neg[4:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_neg_reg  <= d[LOG_W];
            s1_ad_reg   <= d[LOG_W] ? LOG_W'(-d) : d[LOG_W-1:0];
            s1_zero_reg <= zero;

            s2_em_reg   <= em_prod[36:16];
            s2_neg_reg  <= s1_neg_reg;
            s2_zero_reg <= s1_zero_reg;

            s3_f_reg    <= eu[15:0];
            s3_t_reg    <= t_prod[31:16];
            s3_n_reg    <= $signed({1'b0, eu[22:16]}) - 8'sd64;
            s3_zero_reg <= s2_zero_reg;

            s4_p_reg    <= 17'd65536 + {1'b0, p_prod[31:16]};
            s4_n_reg    <= s3_n_reg;
            s4_zero_reg <= s3_zero_reg;

            s5_scale_reg <= scale;
            s6_prod_reg  <= ri * $signed({1'b0, s5_scale_reg});
            s7_inc_reg   <= clamp_inc(div_q16(66'(s6_prod_reg)));
        end
    end

    assign inc = s7_inc_reg;

endmodule
`default_nettype wire

// ===== rtl/core/particle_surface_growth_step_top.sv =====
// Particle surface growth step, pipelined from input transfer to result.
// Throughput is one item per clock; the 31-stage aging divider and the 16-stage
// log2 squaring chain set the depth. A stall on m_ready freezes the whole pipe.
// Reset (aresetn low, synchronous) empties the pipe and loads the register
// defaults: mode 0, ref_increment 0, ref_size 65536, max_size all ones,
// bin_width 0, age_factor 0. Depends on psg_pkg, psg_log2, psg_agediv, psg_incr.
`default_nettype none
module particle_surface_growth_step_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // Input particle channel.
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_particle_size,
    // Result channel.
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_new_size,
    output logic             m_was_updated
);
    import psg_pkg::*;

    // Pipe positions: index 0 is the input register, the log2 results appear
    // at LOG_AT, the increment at INC_AT, the aging quotient at DIV_AT. Three
    // more stages follow: aging product, aging correction, final compare.
    localparam int LOG_AT = 17;
    localparam int INC_AT = LOG_AT + 7;
    localparam int DIV_AT = 34;
    localparam int INC_DLY = DIV_AT - INC_AT;
    localparam int DEPTH = DIV_AT + 4;

    // Configuration registers. Writes must be made only while the pipe is empty
    // (the block does not enforce it); the datapath reads them directly at whichever stage needs them.
    logic [1:0]  mode_reg;
    logic [31:0] ref_inc_reg;
    logic [31:0] ref_size_reg;
    logic [31:0] max_size_reg;
    logic [31:0] bin_width_reg;
    logic [15:0] age_factor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_GROWTH;
            ref_inc_reg    <= 32'd0;
            ref_size_reg   <= 32'd65536;
            max_size_reg   <= 32'hFFFF_FFFF;
            bin_width_reg  <= 32'd0;
            age_factor_reg <= 16'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MODE:          mode_reg       <= cfg_data[1:0];
                REG_REF_INCREMENT: ref_inc_reg    <= cfg_data;
                REG_REF_SIZE:      ref_size_reg   <= cfg_data;
                REG_MAX_SIZE:      max_size_reg   <= cfg_data;
                REG_BIN_WIDTH:     bin_width_reg  <= cfg_data;
                REG_AGE_FACTOR:    age_factor_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // A zero reference or upper bound is treated as one.
    logic [31:0] ref_eff;
    logic [31:0] max_eff;
    assign ref_eff = (ref_size_reg == 32'd0) ? 32'd1 : ref_size_reg;
    assign max_eff = (max_size_reg == 32'd0) ? 32'd1 : max_size_reg;

    // One enable moves every stage; the pipe advances whenever the output
    // register is empty or its result is being transferred.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic        vld_reg  [0:DEPTH-1];
    logic [31:0] size_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < DEPTH; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            size_reg[0] <= s_particle_size;
            for (int i = 1; i < DEPTH; i++) begin
                size_reg[i] <= size_reg[i-1];
            end
        end
    end

    // Log2 of the size and of the reference run side by side.
    logic [LOG_W-1:0] log_s;
    logic [LOG_W-1:0] log_r;

    psg_log2 u_log_size (
        .aclk (aclk),
        .en   (en),
        .x    (size_reg[0]),
        .r    (log_s)
    );

    psg_log2 u_log_ref (
        .aclk (aclk),
        .en   (en),
        .x    (ref_eff),
        .r    (log_r)
    );

    inc_t inc_raw;

    psg_incr u_incr (
        .aclk    (aclk),
        .en      (en),
        .log_s   (log_s),
        .log_r   (log_r),
        .zero    (size_reg[LOG_AT] == 32'd0),
        .ref_inc (ref_inc_reg),
        .inc     (inc_raw)
    );

    logic [Q_W-1:0] age_q;

    psg_agediv u_agediv (
        .aclk    (aclk),
        .en      (en),
        .age     (age_factor_reg),
        .size    (size_reg[0]),
        .divisor (max_eff),
        .q       (age_q)
    );

    // Hold the increment until the aging quotient catches up.
    inc_t inc_dly_reg [0:INC_DLY-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            inc_dly_reg[0] <= inc_raw;
            for (int i = 1; i < INC_DLY; i++) begin
                inc_dly_reg[i] <= inc_dly_reg[i-1];
            end
        end
    end

    // Aging product: increment times the reactivity 65536 - q.
    logic signed [30:0] react;
    wide_t              age_prod_reg;
    inc_t               inc_a1_reg;
    inc_t               inc_a2_reg;

    assign react = 31'sd65536 - $signed({1'b0, age_q});

    always_ff @(posedge aclk) begin
        if (en) begin
            age_prod_reg <= inc_dly_reg[INC_DLY-1] * react;
            inc_a1_reg   <= inc_dly_reg[INC_DLY-1];
            if (mode_reg == MODE_AGING) begin
                inc_a2_reg <= clamp_inc(div_q16(age_prod_reg));
            end else begin
                inc_a2_reg <= inc_a1_reg;
            end
        end
    end

    // Final stage: bound check and saturating update.
    logic signed [37:0] s_w;
    logic signed [37:0] inc_w;
    logic signed [37:0] half_w;
    logic signed [37:0] sum_w;
    logic               apply;
    logic [31:0]        ns;

    always_comb begin
        s_w    = $signed({6'd0, size_reg[DEPTH-2]});
        inc_w  = 38'(inc_a2_reg);
        half_w = $signed({7'd0, bin_width_reg[31:1]});
        if (mode_reg == MODE_OXID) begin
            apply = s_w > ($signed({6'd0, ref_eff}) - half_w - inc_w);
        end else begin
            apply = s_w < ($signed({6'd0, max_eff}) + half_w - inc_w);
        end
        sum_w = s_w + inc_w;
        if (!apply) begin
            ns = size_reg[DEPTH-2];
        end else if (sum_w < 38'sd0) begin
            ns = 32'd0;
        end else if (sum_w > 38'sd4294967295) begin
            ns = 32'hFFFF_FFFF;
        end else begin
            ns = sum_w[31:0];
        end
    end

    logic [31:0] new_size_reg;
    logic        updated_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            new_size_reg <= ns;
            updated_reg  <= apply;
        end
    end

    assign m_valid       = vld_reg[DEPTH-1];
    assign m_new_size    = new_size_reg;
    assign m_was_updated = updated_reg;

`ifndef SYNTHESIS
    // Input is taken exactly when the pipe can move.
    a_ready_tracks_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow the pipe enable");

    // A result only leaves the output through a transfer.
    a_valid_drops_on_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("result dropped without a transfer");

    // The aging quotient of a live item never exceeds its cap.
    a_age_q_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[DIV_AT] |-> (age_q <= AGE_Q_CAP))
        else $error("aging quotient above cap");

    // An item not updated leaves with its size unchanged.
    a_no_update_keeps_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && vld_reg[DEPTH-2] && !apply)
            |=> (new_size_reg == $past(size_reg[DEPTH-2])))
        else $error("size changed without an update");
`endif

endmodule
`default_nettype wire
